// ===== hw/rtl/ir_sweep_object_detector_macros.svh =====
// Assertion macros for the IR sweep object detector.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef IR_SWEEP_OBJECT_DETECTOR_MACROS_SVH
`define IR_SWEEP_OBJECT_DETECTOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define IRSOD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irsod: assertion failed");

// Next-cycle implication, checked outside reset
`define IRSOD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irsod: assertion failed");

`endif

// ===== hw/rtl/irsod_pkg.sv =====
// Shared types and constants for the IR sweep object detector.
// No dependencies.
package irsod_pkg;

  // Field widths
  localparam int ANGLE_W   = 8;
  localparam int READ_W    = 12;
  localparam int LEVEL_W   = 13;
  localparam int COUNT_W   = 6;
  localparam int STEP_W    = 10;
  localparam int FLOOR_W   = 12;
  localparam int MINW_W    = 8;
  localparam int SUM_W     = 14;
  localparam int AVG_W     = 12;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 13;

  // Raw readings are taken on this many low bits
  localparam int SAMPLE_BITS = 12;

  localparam int MAX_OBJECTS_DEF = 32;
  localparam int FIFO_DEPTH      = 2;

  // Divide by three: x * 43691 >> 17 is exact for x below 2^17
  localparam int          RECIP3_W     = 16;
  localparam int          RECIP3_SHIFT = 17;
  localparam logic [15:0] RECIP3       = 16'd43691;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 13'h1FFF;

  // Register defaults
  localparam logic [FLOOR_W-1:0] LEVEL_FLOOR_RST     = 12'd800;
  localparam logic [STEP_W-1:0]  ROUND_STEP_RST      = 10'd100;
  localparam logic [LEVEL_W-1:0] START_THRESHOLD_RST = 13'd800;
  localparam logic [MINW_W-1:0]  MIN_WIDTH_RST       = 8'd8;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_FLOOR     = 4'd0,
    CFG_ROUND_STEP      = 4'd1,
    CFG_START_THRESHOLD = 4'd2,
    CFG_MIN_WIDTH       = 4'd3
  } irsod_cfg_idx_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] level_floor;
    logic [STEP_W-1:0]  round_step;
    logic [LEVEL_W-1:0] start_threshold;
    logic [MINW_W-1:0]  min_width;
  } irsod_cfg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] sweep_angle;
    logic [READ_W-1:0]  reading_a;
    logic [READ_W-1:0]  reading_b;
    logic [READ_W-1:0]  reading_c;
    logic               sweep_end;
  } irsod_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [COUNT_W-1:0] object_count;
    logic               object_done;
    logic [ANGLE_W-1:0] object_width;
    logic [ANGLE_W-1:0] object_center;
    logic               overflow;
    logic               final_res;
    logic               smallest_valid;
    logic [ANGLE_W-1:0] smallest_width;
    logic [ANGLE_W-1:0] smallest_center;
  } irsod_out_t;

  // Classified point handed from front to back
  typedef struct packed {
    logic [AVG_W-1:0]   avg;
    logic [ANGLE_W-1:0] angle;
    logic               last;
  } irsod_work_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_EMIT
  } irsod_bstate_t;

endpackage

// ===== hw/rtl/irsod_front.sv =====
// Front end: accepts sweep points, floors and sums the readings, averages.
// Depends on irsod_pkg.
module irsod_front
  import irsod_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [FLOOR_W-1:0] level_floor,
  input  logic               push,
  output logic               full,
  input  irsod_in_t          in_data,
  output logic               q_push,
  input  logic               q_full,
  output irsod_work_t        q_data
);

  localparam logic [READ_W-1:0] SampleMask =
    (SAMPLE_BITS >= READ_W) ? '1 : READ_W'((1 << SAMPLE_BITS) - 1);

  logic               stg_valid_r, stg_valid_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [ANGLE_W-1:0] angle_r;
  logic               last_r;
  logic               accept;
  logic               advance;
  logic [READ_W-1:0]  fa, fb, fc;
  logic [SUM_W+RECIP3_W-1:0] prod;

  function automatic logic [READ_W-1:0] floor_rd(input logic [READ_W-1:0] raw,
                                                 input logic [FLOOR_W-1:0] flr);
    logic [READ_W-1:0] m;
    m = raw & SampleMask;
    return (m < flr) ? flr : m;
  endfunction

  // Handshake: stage moves into the queue whenever the queue has room
  assign advance = stg_valid_r && !q_full;
  assign full    = stg_valid_r && q_full;
  assign accept  = push && !full;

  // Floor and sum
  always_comb begin
    fa      = floor_rd(in_data.reading_a, level_floor);
    fb      = floor_rd(in_data.reading_b, level_floor);
    fc      = floor_rd(in_data.reading_c, level_floor);
    sum_nxt = SUM_W'(fa) + SUM_W'(fb) + SUM_W'(fc);
    stg_valid_nxt = accept ? 1'b1 : (advance ? 1'b0 : stg_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_r   <= sum_nxt;
      angle_r <= in_data.sweep_angle;
      last_r  <= in_data.sweep_end;
    end
  end

  // Average by reciprocal multiply
  assign prod   = (SUM_W+RECIP3_W)'(sum_r) * (SUM_W+RECIP3_W)'(RECIP3);
  assign q_push = stg_valid_r;
  assign q_data = '{avg:   prod[RECIP3_SHIFT +: AVG_W],
                    angle: angle_r,
                    last:  last_r};

endmodule

// ===== hw/rtl/irsod_fifo.sv =====
// Short queue between front and back ends.
// Depends on irsod_pkg.
module irsod_fifo
  import irsod_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  irsod_work_t wr_data,
  input  logic        pop,
  output logic        empty,
  output irsod_work_t rd_data
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] LastPtr  = PTR_W'(FIFO_DEPTH - 1);

  irsod_work_t        mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == DepthCnt);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== hw/rtl/irsod_back.sv =====
// Back end: iterative rounding remainder, object tracking, result register.
// Depends on irsod_pkg.
module irsod_back
  import irsod_pkg::*;
#(
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  irsod_cfg_t  cfg,
  input  logic        q_empty,
  input  irsod_work_t q_data,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output irsod_out_t  out_data
);

  localparam int CNT_W = $clog2(AVG_W);
  localparam logic [CNT_W-1:0]   LastIter = CNT_W'(AVG_W - 1);
  localparam logic [COUNT_W-1:0] MaxCnt   = COUNT_W'(MAX_OBJECTS);

  irsod_bstate_t state_r, state_nxt;

  // Divider registers
  irsod_work_t         work_r;
  logic [AVG_W-1:0]    quo_r, quo_nxt;
  logic [STEP_W-1:0]   rem_r, rem_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [STEP_W:0]     trial;

  // Sweep tracking
  logic                in_obj_r, in_obj_nxt;
  logic [ANGLE_W-1:0]  st_ang_r, st_ang_nxt;
  logic [LEVEL_W-1:0]  st_lvl_r, st_lvl_nxt;
  logic [COUNT_W-1:0]  seen_r, seen_nxt;
  logic                best_ok_r, best_ok_nxt;
  logic [ANGLE_W-1:0]  best_w_r, best_w_nxt;
  logic [ANGLE_W-1:0]  best_c_r, best_c_nxt;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  irsod_out_t          out_r, out_nxt;

  logic                emit_go;
  logic [SUM_W-1:0]    lvl_wide;
  logic [LEVEL_W-1:0]  lvl;
  logic                done;
  logic [ANGLE_W-1:0]  obj_w, obj_c;
  logic [ANGLE_W:0]    ang_sum;

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign emit_go  = (state_r == B_EMIT) && (!out_valid_r || pop);
  assign empty    = !out_valid_r;
  assign out_data = out_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!q_empty) state_nxt = B_DIV;
      B_DIV:  if (cnt_r == LastIter) state_nxt = B_EMIT;
      B_EMIT: if (emit_go) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Restoring remainder, one quotient bit per cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    trial    = {rem_r, quo_r[AVG_W-1]};
    if (q_pop) begin
      quo_nxt  = q_data.avg;
      rem_nxt  = '0;
      step_nxt = (cfg.round_step == '0) ? STEP_W'(1) : cfg.round_step;
      cnt_nxt  = '0;
    end else if (state_r == B_DIV) begin
      quo_nxt = {quo_r[AVG_W-2:0], 1'b0};
      rem_nxt = (trial >= {1'b0, step_r}) ? STEP_W'(trial - {1'b0, step_r})
                                          : trial[STEP_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    cnt_r  <= cnt_nxt;
    if (q_pop) begin
      work_r <= q_data;
    end
  end

  // Rounding, object edges and smallest tracking
  always_comb begin
    lvl_wide = SUM_W'(work_r.avg) - SUM_W'(rem_r);
    if (rem_r > (step_r >> 1)) begin
      lvl_wide = lvl_wide + SUM_W'(step_r);
    end
    lvl = (lvl_wide > SUM_W'(LEVEL_MAX)) ? LEVEL_MAX : lvl_wide[LEVEL_W-1:0];

    in_obj_nxt  = in_obj_r;
    st_ang_nxt  = st_ang_r;
    st_lvl_nxt  = st_lvl_r;
    seen_nxt    = seen_r;
    best_ok_nxt = best_ok_r;
    best_w_nxt  = best_w_r;
    best_c_nxt  = best_c_r;
    done        = 1'b0;
    obj_w       = '0;
    obj_c       = '0;
    ang_sum     = (ANGLE_W+1)'(work_r.angle) + (ANGLE_W+1)'(st_ang_r);

    if (!in_obj_r) begin
      if (lvl > cfg.start_threshold) begin
        in_obj_nxt = 1'b1;
        st_ang_nxt = work_r.angle;
        st_lvl_nxt = lvl;
      end
    end else if (lvl < st_lvl_r) begin
      done       = 1'b1;
      in_obj_nxt = 1'b0;
      obj_w      = (work_r.angle >= st_ang_r) ? work_r.angle - st_ang_r : '0;
      obj_c      = ang_sum[ANGLE_W:1];
      if (seen_r < MaxCnt) begin
        seen_nxt = seen_r + 1'b1;
        if ((obj_w > cfg.min_width) && (!best_ok_r || obj_w <= best_w_r)) begin
          best_ok_nxt = 1'b1;
          best_w_nxt  = obj_w;
          best_c_nxt  = obj_c;
        end
      end
    end

    out_nxt.level           = lvl;
    out_nxt.object_count    = seen_nxt;
    out_nxt.object_done     = done;
    out_nxt.object_width    = obj_w;
    out_nxt.object_center   = obj_c;
    out_nxt.overflow        = (seen_nxt >= MaxCnt);
    out_nxt.final_res       = work_r.last;
    out_nxt.smallest_valid  = work_r.last && best_ok_nxt;
    out_nxt.smallest_width  = (work_r.last && best_ok_nxt) ? best_w_nxt : '0;
    out_nxt.smallest_center = (work_r.last && best_ok_nxt) ? best_c_nxt : '0;

    // End of sweep returns the tracking state to reset
    if (work_r.last) begin
      in_obj_nxt  = 1'b0;
      st_ang_nxt  = '0;
      st_lvl_nxt  = '0;
      seen_nxt    = '0;
      best_ok_nxt = 1'b0;
      best_w_nxt  = '0;
      best_c_nxt  = '0;
    end

    out_valid_nxt = emit_go ? 1'b1 : (pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_obj_r    <= 1'b0;
      st_ang_r    <= '0;
      st_lvl_r    <= '0;
      seen_r      <= '0;
      best_ok_r   <= 1'b0;
      best_w_r    <= '0;
      best_c_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (emit_go) begin
        in_obj_r  <= in_obj_nxt;
        st_ang_r  <= st_ang_nxt;
        st_lvl_r  <= st_lvl_nxt;
        seen_r    <= seen_nxt;
        best_ok_r <= best_ok_nxt;
        best_w_r  <= best_w_nxt;
        best_c_r  <= best_c_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== hw/rtl/ir_sweep_object_detector.sv =====
// A pushed point is registered in the front stage, then passes the queue, the back
// end's 12-step remainder unit that rounds the average to the step, and the result
// register (empty low). Only then does the back end take a new point.
// The front takes a new point while the back works; a 2-entry queue parts them.
// Reset (rst_n low, synchronous) empties all queues, clears sweep tracking
// and loads the register defaults.
`include "ir_sweep_object_detector_macros.svh"

module ir_sweep_object_detector
  import irsod_pkg::*;
#(
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input queue side
  input  logic                 push,
  output logic                 full,
  input  irsod_in_t            in_data,
  // result queue side
  output logic                 empty,
  input  logic                 pop,
  output irsod_out_t           out_data,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  irsod_cfg_t  cfg_r;
  irsod_work_t q_wdata, q_rdata;
  logic        q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  // Register file decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_floor     <= LEVEL_FLOOR_RST;
      cfg_r.round_step      <= ROUND_STEP_RST;
      cfg_r.start_threshold <= START_THRESHOLD_RST;
      cfg_r.min_width       <= MIN_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LEVEL_FLOOR:     cfg_r.level_floor     <= cfg_data[FLOOR_W-1:0];
        CFG_ROUND_STEP:      cfg_r.round_step      <= cfg_data[STEP_W-1:0];
        CFG_START_THRESHOLD: cfg_r.start_threshold <= cfg_data[LEVEL_W-1:0];
        CFG_MIN_WIDTH:       cfg_r.min_width       <= cfg_data[MINW_W-1:0];
        default: ;
      endcase
    end
  end

  irsod_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .level_floor (cfg_r.level_floor),
    .push        (push),
    .full        (full),
    .in_data     (in_data),
    .q_push      (q_push),
    .q_full      (q_full),
    .q_data      (q_wdata)
  );

  irsod_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .full    (q_full),
    .wr_data (q_wdata),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rdata)
  );

  irsod_back #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  // Smallest-object report appears only on the last point of a sweep
  `IRSOD_ASSERT_IMPL(a_smallest_only_final, !empty && !out_data.final_res, !out_data.smallest_valid)
  // Overflow flag tracks the saturated count
  `IRSOD_ASSERT_IMPL(a_overflow_count, !empty, out_data.overflow == (out_data.object_count >= COUNT_W'(MAX_OBJECTS)))
  // No object closed means width and centre read zero
  `IRSOD_ASSERT_IMPL(a_no_obj_zero, !empty && !out_data.object_done, out_data.object_width == '0 && out_data.object_center == '0)
  // The queue never overfills: front holds its stage while the queue is full
  `IRSOD_ASSERT_NEXT(a_front_holds, q_full && !q_pop && q_push, q_push)

endmodule

// ===== tb/ir_sweep_checker.sv =====
// Result checker for the IR sweep object detector: follows the register,
// point and result channels, predicts every result and compares it field by field.
// Depends on irsod_pkg for the channel types, widths and register defaults.
`timescale 1ns / 1ps

module ir_sweep_checker
  import irsod_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 full,
  input  irsod_in_t            in_data,
  input  logic                 empty,
  input  logic                 pop,
  input  irsod_out_t           out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   mismatches,
  output int                   outstanding,
  output int                   points_checked,
  output int                   objects_closed,
  output int                   saturated_points,
  output int                   smallest_reports
);

  // Register copies
  logic [FLOOR_W-1:0] floor_r;
  logic [STEP_W-1:0]  step_r;
  logic [LEVEL_W-1:0] thresh_r;
  logic [MINW_W-1:0]  minw_r;

  // Sweep tracking
  logic               obj_open;
  logic [ANGLE_W-1:0] open_angle;
  logic [LEVEL_W-1:0] open_level;
  logic [COUNT_W-1:0] count_r;
  logic               best_ok;
  logic [ANGLE_W-1:0] best_w;
  logic [ANGLE_W-1:0] best_c;

  // Predicted results, oldest first
  irsod_out_t expected_reports[$];

  function automatic void clear_sweep();
    obj_open   = 1'b0;
    open_angle = '0;
    open_level = '0;
    count_r    = '0;
    best_ok    = 1'b0;
    best_w     = '0;
    best_c     = '0;
  endfunction

  function automatic logic [READ_W-1:0] raise_to_floor(logic [READ_W-1:0] raw);
    return (raw < floor_r) ? floor_r : raw;
  endfunction

  // Level, object edges and smallest-object tracking for one sweep point
  function automatic irsod_out_t detect_point(irsod_in_t p);
    logic [SUM_W-1:0]   sum;
    logic [AVG_W-1:0]   avg;
    logic [STEP_W-1:0]  quantum;
    logic [STEP_W-1:0]  rem;
    logic [LEVEL_W:0]   rounded;
    logic [LEVEL_W-1:0] lvl;
    logic [ANGLE_W:0]   angle_sum;
    irsod_out_t         r;
    r = '0;
    sum = SUM_W'(raise_to_floor(p.reading_a)) + SUM_W'(raise_to_floor(p.reading_b))
        + SUM_W'(raise_to_floor(p.reading_c));
    avg = AVG_W'(sum / 3);
    // zero step means no rounding
    quantum = (step_r == '0) ? STEP_W'(1) : step_r;
    rem = STEP_W'(avg % quantum);
    rounded = (LEVEL_W+1)'(avg) - (LEVEL_W+1)'(rem);
    if (rem > (quantum >> 1))
      rounded = rounded + (LEVEL_W+1)'(quantum);
    lvl = (rounded > LEVEL_MAX) ? LEVEL_MAX : rounded[LEVEL_W-1:0];
    r.level = lvl;

    if (!obj_open) begin
      if (lvl > thresh_r) begin
        obj_open   = 1'b1;
        open_angle = p.sweep_angle;
        open_level = lvl;
      end
    end else if (lvl < open_level) begin
      obj_open = 1'b0;
      r.object_done = 1'b1;
      // end before start gives zero width
      r.object_width = (p.sweep_angle >= open_angle) ? p.sweep_angle - open_angle : '0;
      angle_sum = {1'b0, p.sweep_angle} + {1'b0, open_angle};
      r.object_center = angle_sum[ANGLE_W:1];
      // saturated count: still reported, neither counted nor a candidate
      if (count_r < MAX_OBJECTS_DEF) begin
        count_r = count_r + 1'b1;
        if (r.object_width > minw_r && (!best_ok || r.object_width <= best_w)) begin
          best_ok = 1'b1;
          best_w  = r.object_width;
          best_c  = r.object_center;
        end
      end
    end

    r.object_count = count_r;
    r.overflow     = (count_r >= MAX_OBJECTS_DEF);
    r.final_res    = p.sweep_end;
    if (p.sweep_end && best_ok) begin
      r.smallest_valid  = 1'b1;
      r.smallest_width  = best_w;
      r.smallest_center = best_c;
    end
    // an object still open at the sweep end is dropped here
    if (p.sweep_end)
      clear_sweep();
    return r;
  endfunction

  task automatic note_failure(string what);
    mismatches++;
    $display("checker: result %0d: %s", points_checked, what);
  endtask

  task automatic compare_report(irsod_out_t got, irsod_out_t want);
    if (got.level !== want.level)
      note_failure($sformatf("level %0d, expected %0d", got.level, want.level));
    if (got.object_count !== want.object_count)
      note_failure($sformatf("object_count %0d, expected %0d",
                             got.object_count, want.object_count));
    if (got.object_done !== want.object_done)
      note_failure($sformatf("object_done %0b, expected %0b",
                             got.object_done, want.object_done));
    if (got.object_width !== want.object_width)
      note_failure($sformatf("object_width %0d, expected %0d",
                             got.object_width, want.object_width));
    if (got.object_center !== want.object_center)
      note_failure($sformatf("object_center %0d, expected %0d",
                             got.object_center, want.object_center));
    if (got.overflow !== want.overflow)
      note_failure($sformatf("overflow %0b, expected %0b", got.overflow, want.overflow));
    if (got.final_res !== want.final_res)
      note_failure($sformatf("final_res %0b, expected %0b", got.final_res, want.final_res));
    if (got.smallest_valid !== want.smallest_valid)
      note_failure($sformatf("smallest_valid %0b, expected %0b",
                             got.smallest_valid, want.smallest_valid));
    if (got.smallest_width !== want.smallest_width)
      note_failure($sformatf("smallest_width %0d, expected %0d",
                             got.smallest_width, want.smallest_width));
    if (got.smallest_center !== want.smallest_center)
      note_failure($sformatf("smallest_center %0d, expected %0d",
                             got.smallest_center, want.smallest_center));
  endtask

  // Channel monitor: results out first, then register writes, then new points
  always @(posedge clk) begin
    if (!rst_n) begin
      floor_r  = LEVEL_FLOOR_RST;
      step_r   = ROUND_STEP_RST;
      thresh_r = START_THRESHOLD_RST;
      minw_r   = MIN_WIDTH_RST;
      clear_sweep();
      expected_reports.delete();
    end else begin
      if (pop && !empty) begin
        points_checked++;
        if (expected_reports.size() == 0)
          note_failure("result transaction with no prediction waiting");
        else
          compare_report(out_data, expected_reports.pop_front());
      end
      if (cfg_valid && cfg_ready) begin
        case (irsod_cfg_idx_t'(cfg_index))
          CFG_LEVEL_FLOOR:     floor_r  = cfg_data[FLOOR_W-1:0];
          CFG_ROUND_STEP:      step_r   = cfg_data[STEP_W-1:0];
          CFG_START_THRESHOLD: thresh_r = cfg_data[LEVEL_W-1:0];
          CFG_MIN_WIDTH:       minw_r   = cfg_data[MINW_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        expected_reports.push_back(detect_point(in_data));
        if (expected_reports[$].object_done)
          objects_closed++;
        if (expected_reports[$].overflow)
          saturated_points++;
        if (expected_reports[$].smallest_valid)
          smallest_reports++;
      end
    end
    outstanding <= expected_reports.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the IR sweep object detector testbench: clock, reset, register
// programming, sweep stimulus and verdict. Depends on irsod_pkg,
// ir_sweep_checker and the ir_sweep_object_detector RTL.
`timescale 1ns / 1ps

module testbench;
  import irsod_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 8;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 push      = 1'b0;
  logic                 full;
  irsod_in_t            in_data   = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  irsod_out_t           out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  int   mismatches;
  int   outstanding;
  int   points_checked;
  int   objects_closed;
  int   saturated_points;
  int   smallest_reports;
  int   points_sent  = 0;
  int   quiet_cycles = 0;
  logic calm         = 1'b0;

  ir_sweep_object_detector DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ir_sweep_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_data          (in_data),
    .empty            (empty),
    .pop              (pop),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .points_checked   (points_checked),
    .objects_closed   (objects_closed),
    .saturated_points (saturated_points),
    .smallest_reports (smallest_reports)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Result side: pop held high with random stall bursts, none once calm
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic irsod_in_t make_point(int angle, int ra, int rb, int rc, bit last);
    irsod_in_t p;
    p.sweep_angle = ANGLE_W'(angle);
    p.reading_a   = READ_W'(ra);
    p.reading_b   = READ_W'(rb);
    p.reading_c   = READ_W'(rc);
    p.sweep_end   = last;
    return p;
  endfunction

  // One point transaction, optionally after a random idle burst
  task automatic send_point(input irsod_in_t p, input bit gaps);
    if (gaps && !calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (full);
    points_sent++;
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back; valid stays high throughout
  task automatic program_registers(input logic [CFG_DAT_W-1:0] floor_v, step_v,
                                   thresh_v, minw_v);
    irsod_cfg_idx_t       order [4];
    logic [CFG_DAT_W-1:0] values [4];
    order  = '{CFG_LEVEL_FLOOR, CFG_ROUND_STEP, CFG_START_THRESHOLD, CFG_MIN_WIDTH};
    values = '{floor_v, step_v, thresh_v, minw_v};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= order[i];
      cfg_data  <= values[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // One sweep: alternating runs of strong and weak returns with rising angle.
  // kind 0: normal runs, 1: single-point runs (many short objects), 2: noise
  task automatic random_sweep(input int len, input int kind, input bit gaps);
    irsod_in_t          p;
    logic [ANGLE_W-1:0] angle;
    bit                 hot_run;
    int                 run_left;
    angle    = ANGLE_W'($urandom_range(0, 20));
    hot_run  = 1'b0;
    run_left = (kind == 1) ? 1 : $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      p.sweep_angle = ($urandom_range(0, 19) == 0) ? ANGLE_W'($urandom_range(0, 255)) : angle;
      if (kind == 2 || $urandom_range(0, 11) == 0) begin
        p.reading_a = READ_W'($urandom_range(0, 4095));
        p.reading_b = READ_W'($urandom_range(0, 4095));
        p.reading_c = READ_W'($urandom_range(0, 4095));
      end else if (hot_run) begin
        p.reading_a = READ_W'($urandom_range(2400, 4095));
        p.reading_b = READ_W'($urandom_range(2400, 4095));
        p.reading_c = READ_W'($urandom_range(2400, 4095));
      end else begin
        p.reading_a = READ_W'($urandom_range(0, 700));
        p.reading_b = READ_W'($urandom_range(0, 700));
        p.reading_c = READ_W'($urandom_range(0, 700));
      end
      p.sweep_end = (i == len - 1);
      send_point(p, gaps);
      angle = angle + ANGLE_W'($urandom_range(1, 3));
      run_left--;
      if (run_left == 0) begin
        hot_run  = !hot_run;
        run_left = (kind == 1) ? 1 : $urandom_range(1, 6);
      end
    end
  endtask

  initial begin : stimulus
    logic [CFG_DAT_W-1:0] floor_v, step_v, thresh_v, minw_v;
    int                   target, pick, kind, len, phase_items;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: register defaults after reset
    send_point(make_point(0, 0, 0, 0, 0), 1'b1);             // floor raise, no open
    send_point(make_point(5, 4095, 4095, 4095, 0), 1'b1);    // rounds up, opens
    send_point(make_point(10, 4095, 4095, 4095, 0), 1'b1);   // same level holds
    send_point(make_point(30, 850, 850, 850, 0), 1'b1);      // half step rounds down, closes
    send_point(make_point(40, 851, 851, 851, 0), 1'b1);      // just over half rounds up
    send_point(make_point(20, 0, 0, 0, 0), 1'b1);            // end angle below start
    send_point(make_point(250, 1000, 2000, 3000, 0), 1'b1);  // angle above 180 opens
    send_point(make_point(255, 4095, 0, 0, 0), 1'b1);        // narrow object
    send_point(make_point(60, 3000, 3000, 3000, 0), 1'b1);
    send_point(make_point(100, 100, 100, 100, 0), 1'b1);     // wider, not smallest
    send_point(make_point(110, 2000, 2000, 2000, 0), 1'b1);
    send_point(make_point(135, 0, 0, 0, 0), 1'b1);           // equal width, later object takes over
    send_point(make_point(140, 3000, 3000, 3000, 0), 1'b1);
    send_point(make_point(180, 3000, 3000, 3000, 1), 1'b1);  // open object dropped at end
    send_point(make_point(0, 0, 0, 0, 1), 1'b1);             // end with no candidate
    drain();

    // Directed: zero step, zero floor, zero threshold, zero minimum width
    program_registers('0, '0, '0, '0);
    send_point(make_point(3, 1, 2, 4, 0), 1'b1);
    send_point(make_point(9, 1, 1, 1, 0), 1'b1);
    send_point(make_point(10, 0, 0, 0, 1), 1'b1);
    drain();

    // Directed: every register at its top value
    program_registers(13'd4095, 13'd1023, 13'd8191, 13'd255);
    send_point(make_point(0, 0, 0, 0, 0), 1'b1);
    send_point(make_point(180, 4095, 4095, 4095, 1), 1'b1);

    // Random phases, one register setting each
    for (int ph = 0; ph < PHASES; ph++) begin
      phase_items = 115;
      case (ph)
        0: begin
          floor_v = 13'd800; step_v = 13'd100; thresh_v = 13'd800; minw_v = 13'd8;
        end
        1: begin
          floor_v = '0; step_v = '0; thresh_v = '0; minw_v = '0;
        end
        2: begin
          floor_v = 13'd4095; step_v = 13'd1023; thresh_v = 13'd8191; minw_v = 13'd255;
          phase_items = 40;
        end
        3: begin
          floor_v = '0; step_v = 13'd1023; thresh_v = '0; minw_v = 13'd180;
          phase_items = 60;
        end
        default: begin
          floor_v  = CFG_DAT_W'($urandom_range(0, 1200));
          step_v   = CFG_DAT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                            : $urandom_range(1, 250));
          thresh_v = floor_v + CFG_DAT_W'($urandom_range(0, 1500));
          minw_v   = CFG_DAT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(0, 24));
          if (ph == PHASES - 1)
            phase_items = 160;
        end
      endcase
      drain();
      program_registers(floor_v, step_v, thresh_v, minw_v);
      calm <= (ph == PHASES - 1);
      target = points_sent + phase_items;
      while (points_sent < target) begin
        pick = $urandom_range(0, 19);
        kind = (pick < 3) ? 1 : (pick < 5) ? 2 : 0;
        len  = (kind == 1) ? $urandom_range(66, 90) : $urandom_range(2, 30);
        random_sweep(len, kind, $urandom_range(0, 3) != 0);
        if (!calm && $urandom_range(0, 19) == 0)
          drain();
      end
    end

    drain();
    $display("summary: %0d points checked across %0d register settings, %0d objects closed",
             points_checked, PHASES + 3, objects_closed);
    $display("summary: %0d results at saturated count, %0d sweep ends with a smallest object",
             saturated_points, smallest_reports);
    if (mismatches == 0 && outstanding == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
